// ----- rtl/circular_list_manager_macros.svh -----
// ----------------------------------------------------------------------------
// circular_list_manager_macros
// Assertion macros used by the list manager controller.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_LIST_MANAGER_MACROS_SVH
`define CIRCULAR_LIST_MANAGER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CLM_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define CLM_ASSERT_NXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/clm_pkg.sv -----
// ----------------------------------------------------------------------------
// clm_pkg
// Types and constants of the circular list manager.
// ----------------------------------------------------------------------------
`default_nettype none

package clm_pkg;

  localparam int unsigned ElementCount = 1024;
  localparam int unsigned IdxW         = 10;
  localparam int unsigned CntW         = 11;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [1:0] {
    OpAdd    = 2'd0,
    OpRemove = 2'd1,
    OpPop    = 2'd2,
    OpLength = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StCheck,
    StAddk,
    StFix,
    StWalk
  } state_e;

  typedef struct packed {
    op_e  op;
    idx_t list_head;
    logic list_empty;
    idx_t element;
  } clm_in_t;

  typedef struct packed {
    idx_t new_head;
    logic new_empty;
    idx_t popped;
    cnt_t count;
    logic error;
  } clm_out_t;

  typedef struct packed {
    logic we;
    idx_t waddr;
    idx_t wdata;
    idx_t raddr;
  } link_req_t;

endpackage

`default_nettype wire

// ----- rtl/clm_link_ram.sv -----
// ----------------------------------------------------------------------------
// clm_link_ram
// One link table: single write port, single registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module clm_link_ram (
  input  wire logic               clk_i,
  input  wire clm_pkg::link_req_t req_i,
  output clm_pkg::idx_t           rdata_o
);

  clm_pkg::idx_t mem [clm_pkg::ElementCount];
  clm_pkg::idx_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/clm_ctrl.sv -----
// ----------------------------------------------------------------------------
// clm_ctrl
// Sequencer: clears links after reset, reads links, checks preconditions, writes back, walks rings.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circular_list_manager_macros.svh"

module clm_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire clm_pkg::clm_in_t   item_i,
  output logic                    done_o,
  output clm_pkg::clm_out_t       result_o,
  output clm_pkg::link_req_t      prev_req_o,
  output clm_pkg::link_req_t      next_req_o,
  input  wire clm_pkg::idx_t      prev_rdata_i,
  input  wire clm_pkg::idx_t      next_rdata_i
);

  clm_pkg::state_e   state_q, state_d;
  clm_pkg::clm_in_t  in_q;
  clm_pkg::clm_out_t res_q, res_d;
  clm_pkg::idx_t     clr_q, clr_d;
  clm_pkg::idx_t     k_q, k_d;
  clm_pkg::idx_t     x_q, x_d;
  clm_pkg::cnt_t     cnt_q, cnt_d;
  logic              done_q, done_d;

  logic              accept;
  logic              clr_last;
  logic              head_ok, el_ok;
  logic              chk_err, chk_fin, chk_unlink;
  clm_pkg::idx_t     head_v;
  clm_pkg::idx_t     rd_first;
  clm_pkg::cnt_t     walk_n;
  logic              walk_end;
  clm_pkg::clm_out_t chk_res;

  assign accept   = start_i && (state_q == clm_pkg::StIdle);
  assign busy_o   = (state_q != clm_pkg::StIdle);
  assign done_o   = done_q;
  assign result_o = res_q;
  assign clr_last = (clr_q == clm_pkg::IdxW'(clm_pkg::ElementCount - 1));

  assign rd_first = ((item_i.op == clm_pkg::OpPop) || (item_i.op == clm_pkg::OpLength)) ?
                    item_i.list_head : item_i.element;

  assign head_ok = in_q.list_empty || (32'(in_q.list_head) < clm_pkg::ElementCount);
  assign el_ok   = (32'(in_q.element) < clm_pkg::ElementCount);
  assign head_v  = in_q.list_empty ? '0 : in_q.list_head;

  assign walk_n   = cnt_q + clm_pkg::CntW'(1);
  assign walk_end = (next_rdata_i == in_q.list_head) ||
                    (walk_n == clm_pkg::CntW'(clm_pkg::ElementCount));

  // precondition check on the first read beat
  always_comb begin
    chk_err    = 1'b0;
    chk_fin    = 1'b1;
    chk_unlink = 1'b0;
    chk_res    = '0;
    case (in_q.op)
      clm_pkg::OpAdd: begin
        chk_err = !el_ok || !head_ok ||
                  (prev_rdata_i != in_q.element) || (next_rdata_i != in_q.element);
        chk_fin = chk_err || in_q.list_empty;
        chk_res.new_head = in_q.list_empty ? in_q.element : in_q.list_head;
      end
      clm_pkg::OpRemove: begin
        chk_err = !el_ok || !head_ok || in_q.list_empty ||
                  ((prev_rdata_i == in_q.element) && (in_q.list_head != in_q.element));
        chk_fin = chk_err || (prev_rdata_i == in_q.element);
        chk_unlink = !chk_fin;
        if (prev_rdata_i == in_q.element) begin
          chk_res.new_empty = 1'b1;
        end else begin
          chk_res.new_head = (in_q.list_head == in_q.element) ? next_rdata_i : in_q.list_head;
        end
      end
      clm_pkg::OpPop: begin
        chk_err = in_q.list_empty || !head_ok;
        chk_fin = chk_err || (prev_rdata_i == in_q.list_head);
        chk_unlink = !chk_fin;
        chk_res.popped = in_q.list_head;
        if (prev_rdata_i == in_q.list_head) begin
          chk_res.new_empty = 1'b1;
        end else begin
          chk_res.new_head = next_rdata_i;
        end
      end
      clm_pkg::OpLength: begin
        chk_err = !head_ok;
        chk_fin = chk_err || in_q.list_empty || (next_rdata_i == in_q.list_head) ||
                  (clm_pkg::ElementCount == 1);
        if (in_q.list_empty) begin
          chk_res.new_empty = 1'b1;
        end else begin
          chk_res.new_head = in_q.list_head;
          chk_res.count    = clm_pkg::CntW'(1);
        end
      end
      default: begin
        chk_err = 1'b1;
      end
    endcase
    if (chk_err) begin
      chk_res.new_head  = head_v;
      chk_res.new_empty = in_q.list_empty;
      chk_res.popped    = '0;
      chk_res.count     = '0;
      chk_res.error     = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      clm_pkg::StClear: begin
        if (clr_last) begin
          state_d = clm_pkg::StIdle;
        end
      end
      clm_pkg::StIdle: begin
        if (accept) begin
          state_d = clm_pkg::StCheck;
        end
      end
      clm_pkg::StCheck: begin
        if (chk_fin) begin
          state_d = clm_pkg::StIdle;
        end else if (in_q.op == clm_pkg::OpAdd) begin
          state_d = clm_pkg::StAddk;
        end else if (in_q.op == clm_pkg::OpLength) begin
          state_d = clm_pkg::StWalk;
        end else begin
          state_d = clm_pkg::StFix;
        end
      end
      clm_pkg::StAddk: begin
        state_d = clm_pkg::StFix;
      end
      clm_pkg::StFix: begin
        state_d = clm_pkg::StIdle;
      end
      clm_pkg::StWalk: begin
        if (walk_end) begin
          state_d = clm_pkg::StIdle;
        end
      end
      default: begin
        state_d = clm_pkg::StClear;
      end
    endcase
  end

  always_comb begin
    prev_req_o = '0;
    next_req_o = '0;
    clr_d      = clr_q;
    k_d        = k_q;
    x_d        = x_q;
    cnt_d      = cnt_q;
    res_d      = res_q;
    done_d     = 1'b0;
    case (state_q)
      clm_pkg::StClear: begin
        prev_req_o.we    = 1'b1;
        prev_req_o.waddr = clr_q;
        prev_req_o.wdata = clr_q;
        next_req_o.we    = 1'b1;
        next_req_o.waddr = clr_q;
        next_req_o.wdata = clr_q;
        clr_d            = clr_q + clm_pkg::IdxW'(1);
      end
      clm_pkg::StIdle: begin
        prev_req_o.raddr = rd_first;
        next_req_o.raddr = rd_first;
      end
      clm_pkg::StCheck: begin
        prev_req_o.raddr = in_q.list_head;
        next_req_o.raddr = next_rdata_i;
        res_d            = chk_res;
        done_d           = chk_fin;
        cnt_d            = clm_pkg::CntW'(1);
        x_d              = (in_q.op == clm_pkg::OpPop) ? in_q.list_head : in_q.element;
        if (chk_unlink) begin
          next_req_o.we    = 1'b1;
          next_req_o.waddr = prev_rdata_i;
          next_req_o.wdata = next_rdata_i;
          prev_req_o.we    = 1'b1;
          prev_req_o.waddr = next_rdata_i;
          prev_req_o.wdata = prev_rdata_i;
        end
      end
      clm_pkg::StAddk: begin
        k_d              = prev_rdata_i;
        next_req_o.we    = 1'b1;
        next_req_o.waddr = prev_rdata_i;
        next_req_o.wdata = in_q.element;
        prev_req_o.we    = 1'b1;
        prev_req_o.waddr = in_q.list_head;
        prev_req_o.wdata = in_q.element;
      end
      clm_pkg::StFix: begin
        done_d           = 1'b1;
        next_req_o.we    = 1'b1;
        prev_req_o.we    = 1'b1;
        next_req_o.waddr = x_q;
        prev_req_o.waddr = x_q;
        if (in_q.op == clm_pkg::OpAdd) begin
          next_req_o.wdata = in_q.list_head;
          prev_req_o.wdata = k_q;
        end else begin
          next_req_o.wdata = x_q;
          prev_req_o.wdata = x_q;
        end
      end
      clm_pkg::StWalk: begin
        next_req_o.raddr = next_rdata_i;
        cnt_d            = walk_n;
        if (walk_end) begin
          done_d      = 1'b1;
          res_d.count = walk_n;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clm_pkg::StClear;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= item_i;
    end
    res_q <= res_d;
    k_q   <= k_d;
    x_q   <= x_d;
    cnt_q <= cnt_d;
  end

  `CLM_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_q, state_q == clm_pkg::StIdle, "done outside idle")
  `CLM_ASSERT_NXT(a_accept_check, clk_i, rst_ni, accept, state_q == clm_pkg::StCheck, "accept lost")
  `CLM_ASSERT_IMP(a_idle_no_write, clk_i, rst_ni, state_q == clm_pkg::StIdle, !prev_req_o.we && !next_req_o.we, "write while idle")
  `CLM_ASSERT_IMP(a_count_len, clk_i, rst_ni, done_q && (res_q.count != '0), in_q.op == clm_pkg::OpLength, "count on non-length op")
  `CLM_ASSERT_IMP(a_err_clean, clk_i, rst_ni, done_q && res_q.error, (res_q.popped == '0) && (res_q.count == '0), "error beat not clean")

endmodule

`default_nettype wire

// ----- rtl/circular_list_manager.sv -----
// Add, remove and pop pass the check state, then the fix state when links change (add via addk first).
// Length walks the ring along the next links until it returns to the head or has counted 1024 members.
// Throughput: one item at a time; busy drops in the cycle the result beat shows.
// Reset: after reset the link tables are rewritten to self-links, all 1024 entries, while busy is high.
// The result beat is not held: the receiver cannot stall it.
// ----------------------------------------------------------------------------
// circular_list_manager
// Circular doubly linked list manager over two link table memories.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_list_manager (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire clm_pkg::clm_in_t item_i,
  output logic                  done_o,
  output clm_pkg::clm_out_t     result_o
);

  clm_pkg::link_req_t prev_req, next_req;
  clm_pkg::idx_t      prev_rdata, next_rdata;

  clm_link_ram u_prev_ram (
    .clk_i   (clk_i),
    .req_i   (prev_req),
    .rdata_o (prev_rdata)
  );

  clm_link_ram u_next_ram (
    .clk_i   (clk_i),
    .req_i   (next_req),
    .rdata_o (next_rdata)
  );

  clm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .item_i       (item_i),
    .done_o       (done_o),
    .result_o     (result_o),
    .prev_req_o   (prev_req),
    .next_req_o   (next_req),
    .prev_rdata_i (prev_rdata),
    .next_rdata_i (next_rdata)
  );

endmodule

`default_nettype wire
